/* hw/rtl/fvm_pkg.sv */
// fvm_pkg: shared types and constants for the fibre lobe voxel metrics block
// no dependencies; imported by fvm_ctrl, fvm_dpath and the top level
package fvm_pkg;

    localparam int DIR_W      = 11;
    localparam int AMP_W      = 16;
    localparam int INT_W      = 24;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 52;
    localparam int FRAC_W     = 17;
    localparam int CNT_W      = 6;
    localparam int EPOCH_W    = 8;
    localparam int DIV_STEPS  = 40;
    localparam int GFA_STEPS  = 32;
    localparam int SQRT_STEPS = 16;
    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    // request codes
    typedef enum logic [1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_LOBE_END  = 2'd1,
        REQ_VOXEL_END = 2'd2,
        REQ_UNUSED    = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_RD,
        ST_MOD,
        ST_ACC,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lobe_upd;
        logic smp_rd;
        logic smp_mod;
        logic smp_acc;
        logic vox_mul;
        logic vox_prep;
        logic div_step;
        logic gfa_step;
        logic sqrt_step;
        logic emit;
        logic sweep_wr;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic epoch_last;
    } t_stat;

endpackage

/* hw/rtl/fod_lobe_voxel_metrics_top.sv */
// Fibre lobe voxel metrics. An item is taken when start is high and busy is low.
// An amplitude sample passes through memory read, modify and write, and square
// accumulate; a lobe end or unused code is taken without leaving idle. A voxel
// end passes a multiply stage, a subtract and compare stage, a 40-step serial
// divider shared in time with the 32-step anisotropy ratio, a 16-step integer
// root and the emit state; the result appears on o_result_valid for one cycle
// and cannot be held off. After reset, and after every 255th voxel when the
// direction tags wrap, a tag sweep clears all NUM_DIRS entries with busy high.
// depends on fvm_pkg, fvm_ctrl, fvm_dpath
module fod_lobe_voxel_metrics_top #(
    parameter int NUM_DIRS = 1281
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_req_type,
    input  logic [fvm_pkg::DIR_W-1:0]          i_dir_index,
    input  logic [fvm_pkg::AMP_W-1:0]          i_amplitude,
    input  logic [fvm_pkg::INT_W-1:0]          i_lobe_integral,
    output logic                               o_result_valid,
    output logic [fvm_pkg::SUM_W-1:0]          o_afd_sum,
    output logic [7:0]                         o_lobe_count,
    output logic [fvm_pkg::FRAC_W-1:0]         o_single_fibre_fraction,
    output logic [fvm_pkg::FRAC_W-1:0]         o_gfa_value,
    output logic                               o_gfa_valid
);
    import fvm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    fvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .busy       (busy)
    );

    // datapath
    fvm_dpath #(.NUM_DIRS(NUM_DIRS)) u_dpath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (w_cmd),
        .o_stat                  (w_stat),
        .i_dir_index             (i_dir_index),
        .i_amplitude             (i_amplitude),
        .i_lobe_integral         (i_lobe_integral),
        .o_result_valid          (o_result_valid),
        .o_afd_sum               (o_afd_sum),
        .o_lobe_count            (o_lobe_count),
        .o_single_fibre_fraction (o_single_fibre_fraction),
        .o_gfa_value             (o_gfa_value),
        .o_gfa_valid             (o_gfa_valid)
    );

endmodule

/* hw/rtl/fvm_ctrl.sv */
// fvm_ctrl: sequencing state machine for the voxel metrics block
// depends on fvm_pkg; drives fvm_dpath through t_cmd, watches t_stat
module fvm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [1:0]                  i_req_type,
    input  fvm_pkg::t_stat              i_stat,
    output fvm_pkg::t_cmd               o_cmd,
    output logic                        busy
);
    import fvm_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               w_accept;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && (r_state == ST_IDLE);

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            ST_SWEEP: if (i_stat.sweep_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req_type)
                        REQ_SAMPLE:    n_state = ST_RD;
                        REQ_VOXEL_END: n_state = ST_MUL;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD:   n_state = ST_MOD;
            ST_MOD:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_IDLE;
            ST_MUL:  n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_SQRT;
                else n_cnt = r_cnt + 1'b1;
            end
            ST_SQRT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = ST_EMIT;
                else n_cnt = r_cnt + 1'b1;
            end
            ST_EMIT: n_state = i_stat.epoch_last ? ST_SWEEP : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = w_accept;
        o_cmd.lobe_upd = w_accept && (i_req_type == REQ_LOBE_END);
        unique case (r_state)
            ST_SWEEP: o_cmd.sweep_wr  = 1'b1;
            ST_RD:    o_cmd.smp_rd    = 1'b1;
            ST_MOD:   o_cmd.smp_mod   = 1'b1;
            ST_ACC:   o_cmd.smp_acc   = 1'b1;
            ST_MUL:   o_cmd.vox_mul   = 1'b1;
            ST_PREP:  o_cmd.vox_prep  = 1'b1;
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.gfa_step = (r_cnt < CNT_W'(GFA_STEPS));
            end
            ST_SQRT:  o_cmd.sqrt_step = 1'b1;
            ST_EMIT:  o_cmd.emit      = 1'b1;
            default:  o_cmd.capture   = w_accept;
        endcase
    end

    // emit leads back to idle or to a tag sweep
    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |=> (r_state == ST_IDLE || r_state == ST_SWEEP))
        else $error("emit did not return to idle or sweep");
    // division runs its full length before the root
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_state == ST_SQRT))
        else $error("division length wrong");
    // at most one memory access per cycle
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.smp_rd, o_cmd.smp_mod, o_cmd.sweep_wr}))
        else $error("memory port conflict");

endmodule

/* hw/rtl/fvm_dpath.sv */
// fvm_dpath: direction memory, accumulators, divider and root unit
// depends on fvm_pkg; commanded by fvm_ctrl
module fvm_dpath #(
    parameter int NUM_DIRS = 1281
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fvm_pkg::t_cmd                      i_cmd,
    output fvm_pkg::t_stat                     o_stat,
    input  logic [fvm_pkg::DIR_W-1:0]          i_dir_index,
    input  logic [fvm_pkg::AMP_W-1:0]          i_amplitude,
    input  logic [fvm_pkg::INT_W-1:0]          i_lobe_integral,
    output logic                               o_result_valid,
    output logic [fvm_pkg::SUM_W-1:0]          o_afd_sum,
    output logic [7:0]                         o_lobe_count,
    output logic [fvm_pkg::FRAC_W-1:0]         o_single_fibre_fraction,
    output logic [fvm_pkg::FRAC_W-1:0]         o_gfa_value,
    output logic                               o_gfa_valid
);
    import fvm_pkg::*;

    localparam int AW = $clog2(NUM_DIRS);
    localparam int NW = $clog2(NUM_DIRS + 1);
    localparam int PW = (SQ_W + NW > 64) ? SQ_W + NW : 64;
    localparam int MW = EPOCH_W + SUM_W;

    // direction memory: epoch tag over running sum
    logic [MW-1:0]      mem [NUM_DIRS];
    logic [MW-1:0]      r_rd_data;

    logic [AW-1:0]      r_addr, r_sweep_addr;
    logic               r_in_range;
    logic [AMP_W-1:0]   r_amp;
    logic [EPOCH_W-1:0] r_epoch;

    logic [SUM_W-1:0]   r_amp_tot, r_int_tot;
    logic [SQ_W-1:0]    r_sq;
    logic [INT_W-1:0]   r_int_max;
    logic [7:0]         r_lobes;
    logic [48:0]        r_delta;

    logic [PW-1:0]      r_nq, r_den, r_gr;
    logic [63:0]        r_s2;
    logic               r_gfull;
    logic [31:0]        r_gq;
    logic [15:0]        r_root;
    logic [17:0]        r_rem;

    logic [39:0]        r_sf_div, r_sf_quo;
    logic [SUM_W-1:0]   r_sf_rem;

    // sample update arithmetic
    logic [SUM_W-1:0]   w_old, w_upd;
    logic [SUM_W:0]     w_sum, w_add;
    logic [AMP_W-1:0]   w_diff;
    logic [48:0]        w_delta;
    logic [SQ_W:0]      w_sq;
    logic [SUM_W:0]     w_amp_tot, w_int_tot;
    logic [63:0]        w_s2;
    logic [PW-1:0]      w_num;
    logic [PW:0]        w_gtw;
    logic [SUM_W:0]     w_sf_rx;
    logic [19:0]        w_rx, w_trial;
    logic [FRAC_W-1:0]  w_sf, w_gfa;

    assign w_old     = (r_rd_data[MW-1:SUM_W] == r_epoch) ? r_rd_data[SUM_W-1:0] : '0;
    assign w_sum     = {1'b0, w_old} + {{(SUM_W + 1 - AMP_W){1'b0}}, r_amp};
    assign w_upd     = w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];
    assign w_diff    = AMP_W'(w_upd - w_old);
    assign w_add     = {1'b0, w_upd} + {1'b0, w_old};
    assign w_delta   = w_diff * w_add;
    assign w_sq      = {1'b0, r_sq} + (SQ_W + 1)'(r_delta);
    assign w_amp_tot = {1'b0, r_amp_tot} + (SUM_W + 1)'(r_amp);
    assign w_int_tot = {1'b0, r_int_tot} + (SUM_W + 1)'(i_lobe_integral);
    assign w_s2      = r_amp_tot * r_amp_tot;
    assign w_num     = (r_nq > PW'(r_s2)) ? r_nq - PW'(r_s2) : '0;
    assign w_gtw     = {r_gr, 1'b0};
    assign w_sf_rx   = {r_sf_rem, r_sf_div[39]};
    assign w_rx      = {r_rem, r_gq[31:30]};
    assign w_trial   = 20'({r_root, 2'b01});

    assign o_stat.sweep_last = (r_sweep_addr == AW'(NUM_DIRS - 1));
    assign o_stat.epoch_last = (r_epoch == '1);

    // result fractions
    always_comb begin
        if (r_int_tot == '0)                w_sf = '0;
        else if (r_sf_quo > 40'(ONE_Q16))   w_sf = ONE_Q16;
        else                                w_sf = r_sf_quo[FRAC_W-1:0];
        if (r_amp_tot == '0 || r_sq == '0)  w_gfa = '0;
        else if (r_gfull)                   w_gfa = ONE_Q16;
        else                                w_gfa = {1'b0, r_root};
    end

    // memory port, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_wr) begin
            mem[r_sweep_addr] <= '0;
        end else if (i_cmd.smp_mod && r_in_range) begin
            mem[r_addr] <= {r_epoch, w_upd};
        end
        if (i_cmd.smp_rd) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr     <= AW'(i_dir_index);
            r_in_range <= (32'(i_dir_index) < NUM_DIRS);
            r_amp      <= i_amplitude;
        end
        if (i_cmd.smp_mod) begin
            r_delta <= r_in_range ? w_delta : '0;
        end
        if (i_cmd.vox_mul) begin
            r_nq     <= PW'(r_sq) * PW'(NUM_DIRS);
            r_den    <= PW'(r_sq) * PW'(NUM_DIRS - 1);
            r_s2     <= w_s2;
            r_sf_div <= {r_int_max, 16'b0};
            r_sf_rem <= '0;
            r_sf_quo <= '0;
        end
        if (i_cmd.vox_prep) begin
            r_gr    <= w_num;
            r_gfull <= (w_num >= r_den);
            r_gq    <= '0;
            r_root  <= '0;
            r_rem   <= '0;
        end
        // fibre fraction: one quotient bit a step
        if (i_cmd.div_step) begin
            r_sf_div <= {r_sf_div[38:0], 1'b0};
            if (w_sf_rx >= {1'b0, r_int_tot}) begin
                r_sf_rem <= SUM_W'(w_sf_rx - {1'b0, r_int_tot});
                r_sf_quo <= {r_sf_quo[38:0], 1'b1};
            end else begin
                r_sf_rem <= SUM_W'(w_sf_rx);
                r_sf_quo <= {r_sf_quo[38:0], 1'b0};
            end
        end
        // anisotropy ratio: one fraction bit a step
        if (i_cmd.gfa_step) begin
            if (w_gtw >= {1'b0, r_den}) begin
                r_gr <= PW'(w_gtw - {1'b0, r_den});
                r_gq <= {r_gq[30:0], 1'b1};
            end else begin
                r_gr <= PW'(w_gtw);
                r_gq <= {r_gq[30:0], 1'b0};
            end
        end
        // integer root: one result bit a step
        if (i_cmd.sqrt_step) begin
            r_gq <= {r_gq[29:0], 2'b00};
            if (w_rx >= w_trial) begin
                r_rem  <= 18'(w_rx - w_trial);
                r_root <= {r_root[14:0], 1'b1};
            end else begin
                r_rem  <= 18'(w_rx);
                r_root <= {r_root[14:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            o_afd_sum               <= r_int_tot;
            o_lobe_count            <= r_lobes;
            o_single_fibre_fraction <= w_sf;
            o_gfa_value             <= w_gfa;
            o_gfa_valid             <= (r_amp_tot != '0);
        end
    end

    // voxel accumulators, epoch and sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_tot      <= '0;
            r_sq           <= '0;
            r_int_tot      <= '0;
            r_int_max      <= '0;
            r_lobes        <= '0;
            r_epoch        <= EPOCH_W'(1);
            r_sweep_addr   <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
            if (i_cmd.sweep_wr) begin
                r_sweep_addr <= o_stat.sweep_last ? '0 : r_sweep_addr + 1'b1;
            end
            if (i_cmd.smp_mod && r_in_range) begin
                r_amp_tot <= w_amp_tot[SUM_W] ? '1 : w_amp_tot[SUM_W-1:0];
            end
            if (i_cmd.smp_acc) begin
                r_sq <= w_sq[SQ_W] ? '1 : w_sq[SQ_W-1:0];
            end
            if (i_cmd.lobe_upd) begin
                r_int_tot <= w_int_tot[SUM_W] ? '1 : w_int_tot[SUM_W-1:0];
                if (i_lobe_integral > r_int_max) r_int_max <= i_lobe_integral;
                if (r_lobes != 8'hFF) r_lobes <= r_lobes + 1'b1;
            end
            if (i_cmd.emit) begin
                r_amp_tot <= '0;
                r_sq      <= '0;
                r_int_tot <= '0;
                r_int_max <= '0;
                r_lobes   <= '0;
                r_epoch   <= o_stat.epoch_last ? EPOCH_W'(1) : r_epoch + 1'b1;
            end
        end
    end

    // result strobe lasts one cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");
    // square total never falls on a sample
    a_sq_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.smp_acc |=> (r_sq >= $past(r_sq)))
        else $error("square total decreased");
    // live epoch never equals the cleared tag
    a_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch reached cleared tag");

endmodule
